FILE: rtl/core/bfa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfa_pkg - shared definitions for the bitmap frame allocator
// Pool geometry, field widths, request and status codes, controller states
// and the priority encoder used for the first-fit search.
// ---------------------------------------------------------------------------
package bfa_pkg;

   // pool geometry
   localparam int unsigned FRAMES      = 1024;
   localparam int unsigned FRAME_BYTES = 4096;
   localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
   localparam int unsigned FRAME_IDX_W = $clog2(FRAMES);
   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int unsigned MAP_WORDS   = FRAMES / WORD_BITS;
   localparam int unsigned WORD_IDX_W  = $clog2(MAP_WORDS);

   // field widths
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned RSP_FIELD_W = ADDR_W + STATUS_W + COUNT_W;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [ADDR_W-1:0]  POOL_BASE_RESET = 32'h0020_0000;
   localparam logic [COUNT_W-1:0] FREE_RESET      = COUNT_W'(FRAMES);

   // request kinds carried on tuser
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_BELOW     = 3'd2,
      ST_UNALIGNED = 3'd3,
      ST_RANGE     = 3'd4,
      ST_DOUBLE    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_LOOKUP = 2'd1,
      S_READ   = 2'd2,
      S_MODIFY = 2'd3
   } state_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [BIT_IDX_W-1:0] first_set(input logic [WORD_BITS-1:0] vec);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bitmap_frame_allocator_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_core - first-fit physical frame allocator
// Keeps one used bit per frame in a word-wide map memory, a per-word full
// flag and a free-frame count. Allocates the lowest free frame and frees
// frames after checking base, alignment, range and double free.
// ---------------------------------------------------------------------------
//
//  channel   direction  fields (low bit first)
//  req_*     in         tuser: mode | tdata: address[31:0]
//  rsp_*     out        tdata: frame_address[31:0], status[34:32],
//                              free_count[45:35], zero pad[47:46]
//  csr_*     in         wdata: pool_base[31:0], written when csr_we is high
//
//  Each request passes through accept, lookup (range checks or first
//  non-full word from the full flags), map memory read, then modify and
//  write back with the result loaded into the output register.
//  The output register holds one result; a request is accepted while it
//  waits, and the modify step stalls only if that result is still untaken.
//  Synchronous reset clears the full flags and row valid flags and loads
//  the free count with FRAMES; rows never written read as all free.
//
module bitmap_frame_allocator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: tuser = mode
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic                              req_tuser,
   // request: tdata = address[31:0]
   input  wire logic [bfa_pkg::ADDR_W-1:0]        req_tdata,
   // response: tdata = frame_address, status, free_count, zero pad
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [bfa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // pool base register
   input  wire logic                              csr_we,
   input  wire logic [bfa_pkg::ADDR_W-1:0]        csr_wdata
);

   localparam int unsigned ADDR_W     = bfa_pkg::ADDR_W;
   localparam int unsigned WORD_BITS  = bfa_pkg::WORD_BITS;
   localparam int unsigned MAP_WORDS  = bfa_pkg::MAP_WORDS;
   localparam int unsigned WORD_IDX_W = bfa_pkg::WORD_IDX_W;
   localparam int unsigned BIT_IDX_W  = bfa_pkg::BIT_IDX_W;
   localparam int unsigned COUNT_W    = bfa_pkg::COUNT_W;
   localparam int unsigned SHIFT      = bfa_pkg::FRAME_SHIFT;
   localparam int unsigned RANGE_LSB  = bfa_pkg::FRAME_SHIFT + bfa_pkg::FRAME_IDX_W;
   localparam int unsigned PAD_W      = bfa_pkg::RSP_DATA_W - bfa_pkg::RSP_FIELD_W;

   bfa_pkg::state_type           state_ff, state_in;
   bfa_pkg::status_type          stat_ff, stat_in;
   bfa_pkg::status_type          fin_stat;

   logic                         mode_ff;
   logic [ADDR_W-1:0]            addr_ff;
   logic [ADDR_W-1:0]            base_ff;
   logic [WORD_IDX_W-1:0]        word_idx_ff, word_idx_in;
   logic [BIT_IDX_W-1:0]         bit_idx_ff, bit_idx_in;

   logic [WORD_BITS-1:0]         map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]         rd_data_ff;
   logic                         rd_valid_ff;
   logic [MAP_WORDS-1:0]         row_valid_ff;
   logic [MAP_WORDS-1:0]         full_ff;
   logic [COUNT_W-1:0]           free_cnt_ff, free_cnt_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bfa_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                         req_fire;
   logic                         out_free;
   logic                         mem_rd;
   logic                         modify_fire;
   logic                         map_we;

   logic [ADDR_W-1:0]            diff;
   logic [MAP_WORDS-1:0]         nonfull;
   logic [WORD_BITS-1:0]         cur_word;
   logic [BIT_IDX_W-1:0]         alloc_bit;
   logic                         bit_used;
   logic [WORD_BITS-1:0]         new_word;
   logic [ADDR_W-1:0]            frame_addr;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = bfa_pkg::S_LOOKUP;
            end
         end
         bfa_pkg::S_LOOKUP: state_in = bfa_pkg::S_READ;
         bfa_pkg::S_READ:   state_in = bfa_pkg::S_MODIFY;
         bfa_pkg::S_MODIFY: begin
            if (out_free) begin
               state_in = bfa_pkg::S_IDLE;
            end
         end
         default: state_in = bfa_pkg::S_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready  = 1'b0;
      mem_rd      = 1'b0;
      modify_fire = 1'b0;
      case (state_ff)
         bfa_pkg::S_IDLE:   req_tready  = 1'b1;
         bfa_pkg::S_LOOKUP: req_tready  = 1'b0;
         bfa_pkg::S_READ:   mem_rd      = 1'b1;
         bfa_pkg::S_MODIFY: modify_fire = out_free;
         default:           req_tready  = 1'b0;
      endcase
   end

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // lookup: screen free requests, pick first non-full word for allocate
   assign diff    = addr_ff - base_ff;
   assign nonfull = ~full_ff;

   always_comb begin
      stat_in     = bfa_pkg::ST_OK;
      word_idx_in = diff[SHIFT+BIT_IDX_W +: WORD_IDX_W];
      bit_idx_in  = diff[SHIFT +: BIT_IDX_W];
      if (mode_ff == bfa_pkg::MODE_ALLOC) begin
         word_idx_in = WORD_IDX_W'(bfa_pkg::first_set(nonfull));
         if (nonfull == '0) begin
            stat_in = bfa_pkg::ST_FULL;
         end
      end else if (addr_ff < base_ff) begin
         stat_in = bfa_pkg::ST_BELOW;
      end else if (addr_ff[SHIFT-1:0] != '0) begin
         stat_in = bfa_pkg::ST_UNALIGNED;
      end else if (diff[ADDR_W-1:RANGE_LSB] != '0) begin
         stat_in = bfa_pkg::ST_RANGE;
      end
   end

   // modify: unwritten rows read as all free
   assign cur_word  = rd_valid_ff ? rd_data_ff : '0;
   assign alloc_bit = bfa_pkg::first_set(~cur_word);
   assign bit_used  = cur_word[bit_idx_ff];

   always_comb begin
      new_word = cur_word;
      fin_stat = stat_ff;
      map_we   = 1'b0;
      free_cnt_in = free_cnt_ff;
      if (stat_ff == bfa_pkg::ST_OK) begin
         if (mode_ff == bfa_pkg::MODE_ALLOC) begin
            new_word[alloc_bit] = 1'b1;
            map_we = modify_fire;
            if (free_cnt_ff != '0) begin
               free_cnt_in = free_cnt_ff - COUNT_W'(1);
            end
         end else if (!bit_used) begin
            fin_stat = bfa_pkg::ST_DOUBLE;
         end else begin
            new_word[bit_idx_ff] = 1'b0;
            map_we = modify_fire;
            if (free_cnt_ff < bfa_pkg::FREE_RESET) begin
               free_cnt_in = free_cnt_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      frame_addr = '0;
      if (stat_ff == bfa_pkg::ST_OK && mode_ff == bfa_pkg::MODE_ALLOC) begin
         frame_addr = base_ff + (ADDR_W'({word_idx_ff, alloc_bit}) << SHIFT);
      end
   end

   // output register: load on modify, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (modify_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= bfa_pkg::POOL_BASE_RESET;
         free_cnt_ff  <= bfa_pkg::FREE_RESET;
         full_ff      <= '0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         if (map_we) begin
            free_cnt_ff               <= free_cnt_in;
            full_ff[word_idx_ff]      <= &new_word;
            row_valid_ff[word_idx_ff] <= 1'b1;
         end
      end
   end

   // request payload and lookup results
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_tuser;
         addr_ff <= req_tdata;
      end
      if (state_ff == bfa_pkg::S_LOOKUP) begin
         stat_ff     <= stat_in;
         word_idx_ff <= word_idx_in;
         bit_idx_ff  <= bit_idx_in;
      end
      if (modify_fire) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, free_cnt_in, fin_stat, frame_addr};
      end
   end

   // map memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[word_idx_ff] <= new_word;
      end
      if (mem_rd) begin
         rd_data_ff  <= map_mem[word_idx_ff];
         rd_valid_ff <= row_valid_ff[word_idx_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: tb/bitmap_frame_allocator_core_tb.sv
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_core_tb - self-checking bench for the frame allocator
// Drives allocate and free requests on the request stream, predicts every
// response from a behavioral copy of the used-frame map and the free count,
// and compares address, status and count of each response in order. Covers
// the directed checks, a full pool and several pool base settings.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ADDR_W      = bfa_pkg::ADDR_W;
   localparam int unsigned COUNT_W     = bfa_pkg::COUNT_W;
   localparam int unsigned RSP_DATA_W  = bfa_pkg::RSP_DATA_W;
   localparam int unsigned FRAMES      = bfa_pkg::FRAMES;
   localparam int unsigned FRAME_BYTES = bfa_pkg::FRAME_BYTES;

   typedef struct packed {
      logic [ADDR_W-1:0]   frame_address;
      bfa_pkg::status_type status;
      logic [COUNT_W-1:0]  free_count;
   } frame_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = bfa_pkg::MODE_ALLOC;
   logic [ADDR_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [ADDR_W-1:0]     csr_wdata  = '0;

   // behavioral allocator state
   bit                    frame_used [FRAMES];
   int unsigned           model_free      = FRAMES;
   logic [ADDR_W-1:0]     pool_base_model = bfa_pkg::POOL_BASE_RESET;

   frame_result_type      pending_results [$];

   bit                    req_idle_on   = 1'b1;
   bit                    rsp_idle_on   = 1'b1;
   int unsigned           rsp_stall_left = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           request_count  = 0;
   int unsigned           ok_count       = 0;
   int unsigned           full_count     = 0;
   int unsigned           reject_count   = 0;
   int unsigned           base_count     = 0;

   bitmap_frame_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                  input logic [ADDR_W-1:0] want);
      if (mismatch_count < 40) begin
         $display("%0t ns: %s: got 0x%h, expected 0x%h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Compute the response to one accepted request and update the map.
   function automatic frame_result_type predict_allocator(input logic mode,
                                                          input logic [ADDR_W-1:0] addr);
      frame_result_type  r;
      int unsigned       slot;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] idx;
      r.frame_address = '0;
      r.status        = bfa_pkg::ST_OK;
      if (mode == bfa_pkg::MODE_ALLOC) begin
         // first fit: lowest clear bit
         slot = 0;
         while (slot < FRAMES && frame_used[slot]) slot++;
         if (slot < FRAMES) begin
            frame_used[slot] = 1'b1;
            if (model_free > 0) model_free--;
            offset = ADDR_W'(slot * FRAME_BYTES);
            r.frame_address = pool_base_model + offset;
         end else begin
            r.status = bfa_pkg::ST_FULL;
         end
      end else begin
         // checks in priority order; the first failure wins
         if (addr < pool_base_model) begin
            r.status = bfa_pkg::ST_BELOW;
         end else if (addr % FRAME_BYTES != 0) begin
            r.status = bfa_pkg::ST_UNALIGNED;
         end else begin
            idx = (addr - pool_base_model) / FRAME_BYTES;
            if (idx >= FRAMES) begin
               r.status = bfa_pkg::ST_RANGE;
            end else if (!frame_used[idx]) begin
               r.status = bfa_pkg::ST_DOUBLE;
            end else begin
               frame_used[idx] = 1'b0;
               if (model_free < FRAMES) model_free++;
            end
         end
      end
      r.free_count = COUNT_W'(model_free);
      if (r.status == bfa_pkg::ST_OK) ok_count++;
      else if (r.status == bfa_pkg::ST_FULL) full_count++;
      else reject_count++;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_address(input int unsigned slot);
      logic [ADDR_W-1:0] offset;
      offset = ADDR_W'(slot * FRAME_BYTES);
      return pool_base_model + offset;
   endfunction

   // Return a random used frame, or FRAMES when none is in use.
   function automatic int unsigned pick_used_slot();
      int unsigned start;
      int unsigned s;
      start = $urandom_range(0, FRAMES - 1);
      for (int unsigned n = 0; n < FRAMES; n++) begin
         s = (start + n) % FRAMES;
         if (frame_used[s]) return s;
      end
      return FRAMES;
   endfunction

   // mostly back-to-back or short gaps, now and then a long one
   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Present one request and hold it until accepted.
   task automatic send_request(input logic mode, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = pick_gap(req_idle_on);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= addr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_allocator(mode, addr));
      request_count++;
   endtask

   // Drain all responses, let the block settle, then write the pool base.
   task automatic write_pool_base(input logic [ADDR_W-1:0] base);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
      pool_base_model = base;
      base_count++;
      @(posedge clock);
   endtask

   // One random request, weighted toward allocations and frees of used frames.
   task automatic random_request();
      int unsigned       pick;
      int unsigned       slot;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(0, 99);
      addr = $urandom();
      if (pick < 45) begin
         send_request(bfa_pkg::MODE_ALLOC, addr);
      end else if (pick < 75) begin
         slot = pick_used_slot();
         if (slot == FRAMES) send_request(bfa_pkg::MODE_ALLOC, addr);
         else send_request(bfa_pkg::MODE_FREE, slot_address(slot));
      end else if (pick < 82) begin
         send_request(bfa_pkg::MODE_FREE, slot_address($urandom_range(0, FRAMES - 1)));
      end else if (pick < 87) begin
         if (pool_base_model != 0) addr = $urandom_range(0, pool_base_model - 1);
         send_request(bfa_pkg::MODE_FREE, addr);
      end else if (pick < 92) begin
         send_request(bfa_pkg::MODE_FREE, slot_address($urandom_range(0, FRAMES - 1))
                                          + $urandom_range(1, FRAME_BYTES - 1));
      end else if (pick < 95) begin
         send_request(bfa_pkg::MODE_FREE, slot_address(FRAMES + $urandom_range(0, 4000)));
      end else begin
         send_request(bfa_pkg::MODE_FREE, addr);
      end
   endtask

   // Field extremes, reuse of a freed frame and each free rejection.
   task automatic test_directed();
      send_request(bfa_pkg::MODE_ALLOC, 32'h0000_0000);
      send_request(bfa_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
      send_request(bfa_pkg::MODE_ALLOC, 32'h5A5A_A5A5);
      send_request(bfa_pkg::MODE_FREE,  slot_address(1));
      send_request(bfa_pkg::MODE_FREE,  slot_address(1));
      send_request(bfa_pkg::MODE_ALLOC, 32'h0000_0000);
      send_request(bfa_pkg::MODE_FREE,  32'h0000_0000);
      send_request(bfa_pkg::MODE_FREE,  pool_base_model - 1);
      send_request(bfa_pkg::MODE_FREE,  pool_base_model + 1);
      send_request(bfa_pkg::MODE_FREE,  32'hFFFF_FFFF);
      send_request(bfa_pkg::MODE_FREE,  slot_address(FRAMES));
      send_request(bfa_pkg::MODE_FREE,  32'hFFFF_F000);
      send_request(bfa_pkg::MODE_FREE,  slot_address(FRAMES - 1));
      send_request(bfa_pkg::MODE_FREE,  slot_address(2) + FRAME_BYTES / 2);
      send_request(bfa_pkg::MODE_FREE,  slot_address(0));
      send_request(bfa_pkg::MODE_FREE,  slot_address(2));
      send_request(bfa_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
   endtask

   // Fill the pool, hit the full case, then free and reuse both end frames.
   task automatic test_pool_full();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      while (model_free != 0) begin
         if (model_free < FRAMES / 2) begin
            req_idle_on = 1'b1;
            rsp_idle_on = 1'b1;
         end
         send_request(bfa_pkg::MODE_ALLOC, $urandom());
      end
      repeat (3) send_request(bfa_pkg::MODE_ALLOC, $urandom());
      send_request(bfa_pkg::MODE_FREE,  slot_address(FRAMES - 1));
      send_request(bfa_pkg::MODE_FREE,  slot_address(0));
      send_request(bfa_pkg::MODE_ALLOC, $urandom());
      send_request(bfa_pkg::MODE_ALLOC, $urandom());
      send_request(bfa_pkg::MODE_ALLOC, $urandom());
   endtask

   // Random traffic under zero, wrapping, unaligned, all-ones and reset bases.
   task automatic test_base_settings();
      logic [ADDR_W-1:0] bases [5];
      bases = '{32'h0000_0000, 32'hFFF0_0000, 32'h1234_5678, 32'hFFFF_FFFF,
                bfa_pkg::POOL_BASE_RESET};
      for (int i = 0; i < 5; i++) begin
         write_pool_base(bases[i]);
         req_idle_on = (i != 1);
         rsp_idle_on = (i != 2);
         repeat (i == 4 ? 110 : 55) random_request();
      end
   endtask

   // Check each response against the oldest prediction; stall at random.
   always @(posedge clock) begin : rsp_check
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request pending", rsp_tdata[31:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.frame_address) begin
               report_mismatch("frame_address", rsp_tdata[31:0], want.frame_address);
            end
            if (rsp_tdata[34:32] !== want.status) begin
               report_mismatch("status", ADDR_W'(rsp_tdata[34:32]), ADDR_W'(want.status));
            end
            if (rsp_tdata[45:35] !== want.free_count) begin
               report_mismatch("free_count", ADDR_W'(rsp_tdata[45:35]),
                               ADDR_W'(want.free_count));
            end
         end
      end
      if (rsp_stall_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall_left = pick_gap(rsp_idle_on);
      end
   end

   // Test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_pool_full();
      test_base_settings();

      // drain and let the pipeline go quiet
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Ran %0d requests across %0d pool base writes, the pool filled to empty.",
               request_count, base_count);
      $display("Responses: %0d ok, %0d out of frames, %0d rejected frees.",
               ok_count, full_count, reject_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bitmap_frame_allocator_core.sv
tb/bitmap_frame_allocator_core_tb.sv
